// ----- sv/lru_key_value_cache_unit_defines.svh -----
// Assertion helpers used by the checker file of the cache unit.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cache unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cache unit assertion failed");

`endif

// ----- sv/lkvc_pkg.sv -----
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic             REQ_GET    = 1'b0;
  localparam logic             REQ_PUT    = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] store_value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } rsp_t;

endpackage

// ----- sv/lru_key_value_cache_unit.sv -----
`timescale 1ns / 1ps
// Fully associative key-value cache of sixteen entries with least-recently-used
// replacement. A get (in_tuser low) returns one result transfer: out_tuser set
// and the stored value on a hit, out_tuser clear and all ones on a miss; a hit
// makes the entry the most recent. A put (in_tuser high) updates or inserts the
// key as most recent and returns nothing; when the live count then exceeds the
// capacity register, the least recent entry is evicted, one per put. Capacities
// above sixteen act as sixteen, and lowering the capacity trims the store by one
// entry per later put that hits or finds a free slot. Each request takes one
// pass through an input register, sixteen parallel key comparators with the
// age-rank update, and a result register, so the unit accepts one request per
// clock; only a stalled output register holds the input side back. The valid
// bits clear in the reset cycle itself, so there is no clearing pass. Write
// cfg_wr_data only while no request is in flight.
module lru_key_value_cache_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration: capacity register.
  input  logic                       cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
  // Request stream.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,   // lookup_key [31:0], store_value [63:32]
  input  logic                       in_tuser,   // req_type: 0 get, 1 put
  // Result stream.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // read_value [31:0]
  output logic                       out_tuser   // hit
);

  logic [lkvc_pkg::CAP_W-1:0] capacity_r;
  logic                       req_valid_r;
  lkvc_pkg::req_t             req_r;
  logic                       req_go;
  logic                       out_can_load;
  logic                       out_load;
  logic                       in_xfer;
  lkvc_pkg::rsp_t             lookup_rsp;

  // The capacity register is written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // A put always leaves the input register; a get needs room for its result.
  assign req_go    = req_valid_r &&
                     ((req_r.req_type == lkvc_pkg::REQ_PUT) || out_can_load);
  assign out_load  = req_go && (req_r.req_type == lkvc_pkg::REQ_GET);
  assign in_tready = !req_valid_r || req_go;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r.req_type    <= in_tuser;
      req_r.lookup_key  <= in_tdata[31:0];
      req_r.store_value <= in_tdata[63:32];
    end
  end

  lkvc_slot_array u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_go   (req_go),
    .cmd      (req_r),
    .capacity (capacity_r),
    .rsp      (lookup_rsp)
  );

  lkvc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .load_rsp   (lookup_rsp),
    .can_load   (out_can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sv/lkvc_slot_array.sv -----
`timescale 1ns / 1ps
// Slot state and the single-pass lookup, recency update and eviction.
module lkvc_slot_array (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_go,
  input  lkvc_pkg::req_t            cmd,
  input  logic [lkvc_pkg::CAP_W-1:0] capacity,
  output lkvc_pkg::rsp_t            rsp
);

  logic                         valid_r   [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::SLOT_W-1:0]  rank_r    [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]   key_r     [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0]   data_r    [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::CNT_W-1:0]   count_r;

  logic                         valid_nxt [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::SLOT_W-1:0]  rank_nxt  [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::CNT_W-1:0]   count_nxt;

  logic                         valid_u   [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::SLOT_W-1:0]  rank_u    [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::CNT_W-1:0]   count_u;

  logic                         hit;
  logic                         has_free;
  logic                         is_put;
  logic                         evict_en;
  logic [lkvc_pkg::SLOT_W-1:0]  hit_idx;
  logic [lkvc_pkg::SLOT_W-1:0]  free_idx;
  logic [lkvc_pkg::SLOT_W-1:0]  oldest_idx;
  logic [lkvc_pkg::SLOT_W-1:0]  ins_idx;
  logic [lkvc_pkg::SLOT_W-1:0]  hit_rank;
  logic [lkvc_pkg::CNT_W-1:0]   last_rank;
  logic [lkvc_pkg::CNT_W-1:0]   last_rank_u;

  assign is_put    = (cmd.req_type == lkvc_pkg::REQ_PUT);
  assign last_rank = count_r - lkvc_pkg::CNT_W'(1);

  // Key match, first free slot and, for a full store, the oldest slot.
  always_comb begin
    hit        = 1'b0;
    has_free   = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    oldest_idx = '0;
    for (int i = lkvc_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == cmd.lookup_key)) begin
        hit     = 1'b1;
        hit_idx = lkvc_pkg::SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = lkvc_pkg::SLOT_W'(i);
      end
      if (valid_r[i] && (lkvc_pkg::CNT_W'(rank_r[i]) == last_rank)) begin
        oldest_idx = lkvc_pkg::SLOT_W'(i);
      end
    end
  end

  assign hit_rank = rank_r[hit_idx];
  assign ins_idx  = has_free ? free_idx : oldest_idx;

  // Recency update for a touch or an insert.
  always_comb begin
    count_u = count_r;
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
      valid_u[i] = valid_r[i];
      rank_u[i]  = rank_r[i];
    end
    if (hit) begin
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_u[i] = rank_r[i] + lkvc_pkg::SLOT_W'(1);
        end
      end
      rank_u[hit_idx] = '0;
    end else if (is_put) begin
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        if (valid_r[i] && (lkvc_pkg::SLOT_W'(i) != ins_idx)) begin
          rank_u[i] = rank_r[i] + lkvc_pkg::SLOT_W'(1);
        end
      end
      valid_u[ins_idx] = 1'b1;
      rank_u[ins_idx]  = '0;
      if (has_free) begin
        count_u = count_r + lkvc_pkg::CNT_W'(1);
      end
    end
  end

  // Eviction after a put: ranks are dense, so the oldest holds count - 1.
  assign last_rank_u = count_u - lkvc_pkg::CNT_W'(1);
  assign evict_en    = is_put && (hit || has_free) &&
                       (lkvc_pkg::CMP_W'(count_u) > lkvc_pkg::CMP_W'(capacity));

  always_comb begin
    count_nxt = evict_en ? last_rank_u : count_u;
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
      valid_nxt[i] = valid_u[i];
      rank_nxt[i]  = rank_u[i];
      if (evict_en && valid_u[i] && (lkvc_pkg::CNT_W'(rank_u[i]) == last_rank_u)) begin
        valid_nxt[i] = 1'b0;
        rank_nxt[i]  = '0;
      end
    end
  end

  assign rsp.hit        = hit;
  assign rsp.read_value = hit ? data_r[hit_idx] : lkvc_pkg::MISS_VALUE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else if (cmd_go) begin
      count_r <= count_nxt;
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
  end

  // Key and value storage carries no reset.
  always_ff @(posedge clk) begin
    if (cmd_go && is_put) begin
      if (hit) begin
        data_r[hit_idx] <= cmd.store_value;
      end else begin
        key_r[ins_idx]  <= cmd.lookup_key;
        data_r[ins_idx] <= cmd.store_value;
      end
    end
  end

endmodule

// ----- sv/lkvc_out_reg.sv -----
`timescale 1ns / 1ps
// One-entry result register on the output stream.
module lkvc_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  lkvc_pkg::rsp_t             load_rsp,
  output logic                       can_load,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lkvc_pkg::VAL_W-1:0] out_tdata,
  output logic                       out_tuser
);

  logic           valid_r;
  logic           valid_nxt;
  lkvc_pkg::rsp_t rsp_r;

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= load_rsp;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = rsp_r.read_value;
  assign out_tuser  = rsp_r.hit;

endmodule

// ----- sv/lkvc_checker.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_defines.svh"
// Port-level checks on the cache unit.
module lkvc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A miss always carries the all-ones value.
  `LKVC_ASSERT_IMPL(a_miss_value, clk, rst_n, out_tvalid && !out_tuser, out_tdata == lkvc_pkg::MISS_VALUE)

  // With the result register empty, nothing can hold back the input side.
  `LKVC_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  // No result is pending right after reset is released.
  `LKVC_ASSERT_IMPL(a_empty_after_reset, clk, rst_n, !$past(rst_n), !out_tvalid)

  // A stalled result holds its value.
  `LKVC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
